>>> rtl/dts_lex_pkg.sv
package dts_lex_pkg;

  localparam int TEXT_LIMIT = 64;
  localparam int LEN_W = $clog2(TEXT_LIMIT);
  localparam int MAX_RES = 4;

  localparam logic [3:0] MODE_START = 4'd0;
  localparam logic [3:0] MODE_SLASH = 4'd1;
  localparam logic [3:0] MODE_LINE = 4'd2;
  localparam logic [3:0] MODE_BLOCK = 4'd3;
  localparam logic [3:0] MODE_STAR = 4'd4;
  localparam logic [3:0] MODE_IDENT = 4'd5;
  localparam logic [3:0] MODE_NUMBER = 4'd6;
  localparam logic [3:0] MODE_STRING = 4'd7;
  localparam logic [3:0] MODE_ESCAPE = 4'd8;

  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  localparam logic [4:0] T_END = 5'd0;
  localparam logic [4:0] T_IDENT = 5'd1;
  localparam logic [4:0] T_STRING = 5'd2;
  localparam logic [4:0] T_NUMBER = 5'd3;
  localparam logic [4:0] T_PUNCT0 = 5'd4;
  localparam logic [4:0] T_SLASH = 5'd14;
  localparam logic [4:0] T_ERROR = 5'd18;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END = 1'b1;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_EOF = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [7:0]        text;
    logic [4:0]        ttype;
    logic [23:0]       line;
    logic [15:0]       column;
    logic [63:0]       value;
    logic [5:0]        length;
    logic              last;
  } dts_res_t;

  typedef struct packed {
    dts_res_t [MAX_RES-1:0] res;
    logic [2:0]             count;
  } dts_bundle_t;

  typedef struct packed {
    logic [3:0]       mode;
    logic [23:0]      line_count;
    logic [15:0]      column_count;
    logic [23:0]      tok_line;
    logic [15:0]      tok_col;
    logic [LEN_W-1:0] klen;
    logic [63:0]      acc;
    logic [1:0]       base;
    logic             stopped;
  } dts_state_t;

  localparam dts_state_t RESET_STATE = '{
    mode: MODE_START, line_count: 24'd1, column_count: 16'd0,
    tok_line: 24'd1, tok_col: 16'd0, klen: '0, acc: 64'd0,
    base: BASE_DEC, stopped: 1'b0
  };

  // Digit value of a hex digit, 16 for anything else.
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd16;
    if (c >= "0" && c <= "9") d = 5'(c - "0");
    else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
    return d;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Token type of a single-character token, T_END when the byte is none.
  function automatic logic [4:0] punct_type(input logic [7:0] c);
    logic [4:0] t;
    case (c)
      "{": t = T_PUNCT0;
      "}": t = T_PUNCT0 + 5'd1;
      "<": t = T_PUNCT0 + 5'd2;
      ">": t = T_PUNCT0 + 5'd3;
      "[": t = T_PUNCT0 + 5'd4;
      "]": t = T_PUNCT0 + 5'd5;
      ";": t = T_PUNCT0 + 5'd6;
      "=": t = T_PUNCT0 + 5'd7;
      ",": t = T_PUNCT0 + 5'd8;
      "@": t = T_PUNCT0 + 5'd9;
      "/": t = T_SLASH;
      "&": t = T_PUNCT0 + 5'd11;
      "#": t = T_PUNCT0 + 5'd12;
      ":": t = T_PUNCT0 + 5'd13;
      default: t = T_END;
    endcase
    return t;
  endfunction

  function automatic dts_res_t make_res(input logic kind, input logic [7:0] text,
                                        input logic [4:0] ttype, input dts_state_t s,
                                        input logic [63:0] value);
    dts_res_t r;
    logic [8:0] kx;
    kx = 9'(s.klen);
    r.kind = kind;
    r.text = text;
    r.ttype = ttype;
    r.line = s.tok_line;
    r.column = s.tok_col;
    r.value = value;
    r.length = (kx > 9'd63) ? 6'd63 : kx[5:0];
    r.last = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/devicetree_source_tokenizer.sv
// Each accepted byte is lexed combinationally; its results (up to four) are
// buffered and delivered in order, one transfer per cycle while m_tready is high.
// Throughput: one byte per cycle while the output keeps up; two bundles of
// results are buffered, and bytes wait only while both are occupied.
// Reset (rst, synchronous) returns the lexer to its start state at line 1,
// column 0, and empties the result buffer.
module devicetree_source_tokenizer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // byte_req
  input  logic         s_tuser,   // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // text_byte, token_type, line, column, number_value,
                                  // text_length, zero fill
  output logic         m_tuser,   // kind
  output logic         m_tlast    // last
);

  dts_lex_pkg::dts_state_t  state;
  dts_lex_pkg::dts_state_t  state_next;
  dts_lex_pkg::dts_bundle_t bundle;
  dts_lex_pkg::dts_res_t    res;
  logic                     space;
  logic                     accept;

  assign s_tready = space;
  assign accept = s_tvalid && s_tready;

  dts_lex_step u_step (
    .cur    (state),
    .action (s_tuser),
    .c      (s_tdata),
    .nxt    (state_next),
    .bundle (bundle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dts_lex_pkg::RESET_STATE;
    end else if (accept) begin
      state <= state_next;
    end
  end

  dts_lex_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (accept && bundle.count != 3'd0),
    .push_bundle (bundle),
    .space       (space),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_res     (res)
  );

  assign m_tdata = {5'd0, res.length, res.value, res.column, res.line, res.ttype, res.text};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule

>>> rtl/dts_lex_step.sv
module dts_lex_step (
  input  dts_lex_pkg::dts_state_t  cur,
  input  logic                     action,
  input  logic [7:0]               c,
  output dts_lex_pkg::dts_state_t  nxt,
  output dts_lex_pkg::dts_bundle_t bundle
);

  always_comb begin
    dts_lex_pkg::dts_state_t s;
    dts_lex_pkg::dts_res_t [dts_lex_pkg::MAX_RES-1:0] res;
    logic [2:0]  cnt;
    logic        do_start;
    logic [4:0]  pt;
    logic [4:0]  d;
    logic [4:0]  radix;
    logic [67:0] prod;
    logic        kept;

    s = cur;
    res = '0;
    cnt = 3'd0;
    do_start = 1'b0;
    pt = dts_lex_pkg::T_END;
    d = 5'd0;
    radix = 5'd10;
    prod = '0;
    kept = 1'b0;

    if (action == dts_lex_pkg::ACT_EOF) begin
      case (s.mode)
        dts_lex_pkg::MODE_IDENT: begin
          res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_END, 8'd0,
                                                dts_lex_pkg::T_IDENT, s, 64'd0);
          cnt = cnt + 3'd1;
        end
        dts_lex_pkg::MODE_NUMBER: begin
          res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_END, 8'd0,
                                                dts_lex_pkg::T_NUMBER, s, s.acc);
          cnt = cnt + 3'd1;
        end
        dts_lex_pkg::MODE_STRING, dts_lex_pkg::MODE_ESCAPE: begin
          res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_END, 8'd0,
                                                dts_lex_pkg::T_STRING, s, 64'd0);
          cnt = cnt + 3'd1;
        end
        dts_lex_pkg::MODE_SLASH: begin
          if (32'(s.klen) < dts_lex_pkg::TEXT_LIMIT - 1) begin
            s.klen = s.klen + 1'b1;
            res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_TEXT, "/",
                                                  dts_lex_pkg::T_SLASH, s, 64'd0);
            cnt = cnt + 3'd1;
          end
          res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_END, 8'd0,
                                                dts_lex_pkg::T_SLASH, s, 64'd0);
          cnt = cnt + 3'd1;
        end
        default: begin
        end
      endcase
      s.tok_line = s.line_count;
      s.tok_col = (s.column_count == 16'hFFFF) ? 16'hFFFF : s.column_count + 16'd1;
      s.klen = '0;
      res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_END, 8'd0,
                                            dts_lex_pkg::T_END, s, 64'd0);
      cnt = cnt + 3'd1;
      s = dts_lex_pkg::RESET_STATE;
    end else begin
      if (c == 8'h0A) begin
        if (s.line_count != 24'hFFFFFF) s.line_count = s.line_count + 24'd1;
        s.column_count = 16'd0;
      end else if (s.column_count != 16'hFFFF) begin
        s.column_count = s.column_count + 16'd1;
      end

      case (s.mode)
        dts_lex_pkg::MODE_SLASH: begin
          if (c == "/") begin
            s.mode = dts_lex_pkg::MODE_LINE;
          end else if (c == "*") begin
            s.mode = dts_lex_pkg::MODE_BLOCK;
          end else begin
            if (32'(s.klen) < dts_lex_pkg::TEXT_LIMIT - 1) begin
              s.klen = s.klen + 1'b1;
              res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_TEXT, "/",
                                                    dts_lex_pkg::T_SLASH, s, 64'd0);
              cnt = cnt + 3'd1;
            end
            res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_END, 8'd0,
                                                  dts_lex_pkg::T_SLASH, s, 64'd0);
            cnt = cnt + 3'd1;
            do_start = 1'b1;
          end
        end
        dts_lex_pkg::MODE_LINE: begin
          if (c == 8'h0A) s.mode = dts_lex_pkg::MODE_START;
        end
        dts_lex_pkg::MODE_BLOCK: begin
          if (c == "*") s.mode = dts_lex_pkg::MODE_STAR;
        end
        dts_lex_pkg::MODE_STAR: begin
          if (c == "/") s.mode = dts_lex_pkg::MODE_START;
          else if (c != "*") s.mode = dts_lex_pkg::MODE_BLOCK;
        end
        dts_lex_pkg::MODE_IDENT: begin
          if (dts_lex_pkg::is_alpha(c) || dts_lex_pkg::is_digit(c) || c == "-" ||
              c == "_" || c == "," || c == ".") begin
            if (32'(s.klen) < dts_lex_pkg::TEXT_LIMIT - 1) begin
              s.klen = s.klen + 1'b1;
              res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_TEXT, c,
                                                    dts_lex_pkg::T_IDENT, s, 64'd0);
              cnt = cnt + 3'd1;
            end
          end else begin
            res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_END, 8'd0,
                                                  dts_lex_pkg::T_IDENT, s, 64'd0);
            cnt = cnt + 3'd1;
            do_start = 1'b1;
          end
        end
        dts_lex_pkg::MODE_NUMBER: begin
          d = dts_lex_pkg::digit_value(c);
          if (d < 5'd16 || c == "x" || c == "X") begin
            if (32'(s.klen) < dts_lex_pkg::TEXT_LIMIT - 1) begin
              s.klen = s.klen + 1'b1;
              res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_TEXT, c,
                                                    dts_lex_pkg::T_NUMBER, s, 64'd0);
              cnt = cnt + 3'd1;
              kept = 1'b1;
            end
            if (kept && !s.stopped) begin
              if (s.base == dts_lex_pkg::BASE_OCT && 32'(s.klen) == 2 &&
                  (c == "x" || c == "X")) begin
                s.base = dts_lex_pkg::BASE_HEX;
              end else begin
                radix = (s.base == dts_lex_pkg::BASE_HEX) ? 5'd16 :
                        ((s.base == dts_lex_pkg::BASE_OCT) ? 5'd8 : 5'd10);
                if (d >= radix) begin
                  s.stopped = 1'b1;
                end else begin
                  if (s.base == dts_lex_pkg::BASE_HEX)
                    prod = {s.acc, 4'b0};
                  else if (s.base == dts_lex_pkg::BASE_OCT)
                    prod = {1'b0, s.acc, 3'b0};
                  else
                    prod = {1'b0, s.acc, 3'b0} + {3'b0, s.acc, 1'b0};
                  prod = prod + 68'(d);
                  // Anything past 64 bits means the value no longer fits.
                  s.acc = (prod[67:64] != 4'd0) ? '1 : prod[63:0];
                end
              end
            end
          end else begin
            res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_END, 8'd0,
                                                  dts_lex_pkg::T_NUMBER, s, s.acc);
            cnt = cnt + 3'd1;
            do_start = 1'b1;
          end
        end
        dts_lex_pkg::MODE_STRING: begin
          if (c == "\"") begin
            res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_END, 8'd0,
                                                  dts_lex_pkg::T_STRING, s, 64'd0);
            cnt = cnt + 3'd1;
            s.mode = dts_lex_pkg::MODE_START;
          end else begin
            if (32'(s.klen) < dts_lex_pkg::TEXT_LIMIT - 1) begin
              s.klen = s.klen + 1'b1;
              res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_TEXT, c,
                                                    dts_lex_pkg::T_STRING, s, 64'd0);
              cnt = cnt + 3'd1;
            end
            if (c == "\\") s.mode = dts_lex_pkg::MODE_ESCAPE;
          end
        end
        dts_lex_pkg::MODE_ESCAPE: begin
          if (32'(s.klen) < dts_lex_pkg::TEXT_LIMIT - 1) begin
            s.klen = s.klen + 1'b1;
            res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_TEXT, c,
                                                  dts_lex_pkg::T_STRING, s, 64'd0);
            cnt = cnt + 3'd1;
          end
          s.mode = dts_lex_pkg::MODE_STRING;
        end
        default: begin
          do_start = 1'b1;
        end
      endcase

      // A byte that is not white space opens a new token, possibly right after closing the last one.
      if (do_start) begin
        s.mode = dts_lex_pkg::MODE_START;
        pt = dts_lex_pkg::punct_type(c);
        if (!dts_lex_pkg::is_space(c)) begin
          s.tok_line = s.line_count;
          s.tok_col = s.column_count;
          s.klen = '0;
          s.acc = 64'd0;
          s.base = dts_lex_pkg::BASE_DEC;
          s.stopped = 1'b0;
          if (c == "/") begin
            s.mode = dts_lex_pkg::MODE_SLASH;
          end else if (pt != dts_lex_pkg::T_END) begin
            s.klen = s.klen + 1'b1;
            res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_TEXT, c, pt, s, 64'd0);
            cnt = cnt + 3'd1;
            res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_END, 8'd0, pt, s, 64'd0);
            cnt = cnt + 3'd1;
          end else if (c == "\"") begin
            s.mode = dts_lex_pkg::MODE_STRING;
          end else if (dts_lex_pkg::is_digit(c)) begin
            s.base = (c == "0") ? dts_lex_pkg::BASE_OCT : dts_lex_pkg::BASE_DEC;
            s.acc = 64'(c - "0");
            s.klen = s.klen + 1'b1;
            res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_TEXT, c,
                                                  dts_lex_pkg::T_NUMBER, s, 64'd0);
            cnt = cnt + 3'd1;
            s.mode = dts_lex_pkg::MODE_NUMBER;
          end else if (dts_lex_pkg::is_alpha(c) || c == "_") begin
            s.klen = s.klen + 1'b1;
            res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_TEXT, c,
                                                  dts_lex_pkg::T_IDENT, s, 64'd0);
            cnt = cnt + 3'd1;
            s.mode = dts_lex_pkg::MODE_IDENT;
          end else begin
            s.klen = s.klen + 1'b1;
            res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_TEXT, c,
                                                  dts_lex_pkg::T_ERROR, s, 64'd0);
            cnt = cnt + 3'd1;
            res[cnt[1:0]] = dts_lex_pkg::make_res(dts_lex_pkg::KIND_END, 8'd0,
                                                  dts_lex_pkg::T_ERROR, s, 64'd0);
            cnt = cnt + 3'd1;
          end
        end
      end
    end

    if (cnt != 3'd0) res[2'(cnt - 3'd1)].last = 1'b1;
    nxt = s;
    bundle.res = res;
    bundle.count = cnt;
  end

endmodule

>>> rtl/dts_lex_queue.sv
module dts_lex_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  dts_lex_pkg::dts_bundle_t push_bundle,
  output logic                     space,
  output logic                     out_valid,
  input  logic                     out_ready,
  output dts_lex_pkg::dts_res_t    out_res
);

  dts_lex_pkg::dts_bundle_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] occ;
  logic [1:0] idx;
  logic       pop_item;
  logic       pop_bundle;

  assign space = (occ != 2'd2);
  assign out_valid = (occ != 2'd0);
  assign out_res = slots[rd_ptr].res[idx];
  assign pop_item = out_valid && out_ready;
  assign pop_bundle = pop_item && (3'(idx) + 3'd1 == slots[rd_ptr].count);

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      occ <= 2'd0;
      idx <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop_bundle) begin
        rd_ptr <= ~rd_ptr;
        idx <= 2'd0;
      end else if (pop_item) begin
        idx <= idx + 2'd1;
      end
      occ <= occ + {1'b0, push} - {1'b0, pop_bundle};
    end
  end

endmodule
